[src/rswe_pkg.sv]
// Shared package for the Reno sender window engine.
// Holds constants, codes, phase and state enums, controller/datapath structs and a helper.
// No dependencies.
package rswe_pkg;

  // segment and sequence space
  localparam int unsigned MSS        = 1024;
  localparam int unsigned SEQ_SPACE  = 256;
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_CAP   = (RING_DEPTH < SEQ_SPACE) ? RING_DEPTH : SEQ_SPACE - 1;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned SEQ_W      = 8;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned WIN_W      = 24;
  localparam int unsigned BYTE_W     = 32;
  localparam int unsigned RCNT_W     = 7;

  // avoidance divider: numerator d * MSS * MSS
  localparam longint unsigned MSS_SQ = longint'(MSS) * longint'(MSS);
  localparam int unsigned MSS_SQ_W   = $clog2(MSS_SQ + 1);
  localparam int unsigned NUM_W      = SEQ_W + MSS_SQ_W;
  localparam int unsigned DCNT_W     = $clog2(NUM_W);

  localparam logic [WIN_W-1:0] CAP24     = '1;
  localparam logic [WIN_W-1:0] MSS_W24   = WIN_W'(MSS);
  localparam logic [WIN_W-1:0] MSS3_W24  = WIN_W'(3 * MSS);
  localparam logic [WIN_W-1:0] INIT_THR  = WIN_W'(6144);
  localparam logic [WIN_W-1:0] INIT_WLIM = WIN_W'(1024);

  // register indexes on the configuration port
  localparam logic [1:0] CFG_TOTAL = 2'd0;
  localparam logic [1:0] CFG_WLIM  = 2'd1;
  localparam logic [1:0] CFG_ITHR  = 2'd2;

  // event kinds
  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_ACK  = 2'd1;
  localparam logic [1:0] REQ_TMO  = 2'd2;

  // retransmit orders
  localparam logic [1:0] RTX_NONE = 2'd0;
  localparam logic [1:0] RTX_TMO  = 2'd1;
  localparam logic [1:0] RTX_FAST = 2'd2;

  localparam logic [2:0] DUP_MAX = 3'd7;
  localparam logic [2:0] DUP_TRG = 3'd3;

  localparam int unsigned OUT_W = 104;

  typedef enum logic [1:0] {
    PH_SLOW  = 2'd0,
    PH_AVOID = 2'd1,
    PH_RECOV = 2'd2
  } cc_phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEND_CHK,
    S_SEND_DO,
    S_ACK_CHK,
    S_SUM,
    S_DRAIN,
    S_ACK_UPD,
    S_DIV,
    S_DIV_FIN,
    S_DUP,
    S_TMO,
    S_TIMER,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic send_chk;
    logic send_do;
    logic ack_chk;
    logic sum_step;
    logic sum_drain;
    logic ack_upd;
    logic div_step;
    logic div_fin;
    logic dup_upd;
    logic tmo_upd;
    logic timer_upd;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       in_win;
    logic       sum_last;
    logic       div_last;
    logic       avoid;
    logic       out_free;
  } ctrl_sts_t;

  // clamp to the 24-bit window range
  function automatic logic [WIN_W-1:0] sat24(input logic [BYTE_W:0] v);
    sat24 = (v > {{(BYTE_W+1-WIN_W){1'b0}}, CAP24}) ? CAP24 : v[WIN_W-1:0];
  endfunction

endpackage

[src/rswe_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rswe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/rswe_ctrl.sv]
// Event sequencer for the window engine: steps each event through its stages.
// Depends on rswe_pkg.
module rswe_ctrl import rswe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          priority case (sts_i.req)
            REQ_SEND: state_d = S_SEND_CHK;
            REQ_ACK:  state_d = S_ACK_CHK;
            REQ_TMO:  state_d = S_TMO;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_SEND_CHK: state_d = S_SEND_DO;
      S_SEND_DO:  state_d = S_DONE;
      S_ACK_CHK:  state_d = sts_i.in_win ? S_SUM : S_DUP;
      S_SUM:      state_d = sts_i.sum_last ? S_DRAIN : S_SUM;
      S_DRAIN:    state_d = S_ACK_UPD;
      S_ACK_UPD:  state_d = sts_i.avoid ? S_DIV : S_TIMER;
      S_DIV:      state_d = sts_i.div_last ? S_DIV_FIN : S_DIV;
      S_DIV_FIN:  state_d = S_TIMER;
      S_DUP:      state_d = S_TIMER;
      S_TMO:      state_d = S_DONE;
      S_TIMER:    state_d = S_DONE;
      S_DONE:     state_d = sts_i.out_free ? S_IDLE : S_DONE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_SEND_CHK: cmd_o.send_chk  = 1'b1;
      S_SEND_DO:  cmd_o.send_do   = 1'b1;
      S_ACK_CHK:  cmd_o.ack_chk   = 1'b1;
      S_SUM:      cmd_o.sum_step  = 1'b1;
      S_DRAIN:    cmd_o.sum_drain = 1'b1;
      S_ACK_UPD:  cmd_o.ack_upd   = 1'b1;
      S_DIV:      cmd_o.div_step  = 1'b1;
      S_DIV_FIN:  cmd_o.div_fin   = 1'b1;
      S_DUP:      cmd_o.dup_upd   = 1'b1;
      S_TMO:      cmd_o.tmo_upd   = 1'b1;
      S_TIMER:    cmd_o.timer_upd = 1'b1;
      S_DONE:     cmd_o.load_out  = sts_i.out_free;
      default:    cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/rswe_dp.sv]
// Datapath of the window engine: window state, byte counters, segment ring,
// ACK summation, avoidance divider and the output register.
// Depends on rswe_pkg and rswe_ram.
module rswe_dp import rswe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  input  logic [1:0]        in_req_i,
  input  logic [SEQ_W-1:0]  in_ack_i,
  input  ctrl_cmd_t         cmd_i,
  output ctrl_sts_t         sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  out_data_o
);

  // configuration
  logic [BYTE_W-1:0] total_q;
  logic [WIN_W-1:0]  wlim_q;

  // window state
  logic [WIN_W-1:0]   cwnd_q, cwnd_d;
  logic [WIN_W-1:0]   thr_q, thr_d;
  cc_phase_e          phase_q, phase_d;
  logic [2:0]         dup_q, dup_d;
  logic [SEQ_W-1:0]   base_q, base_d;
  logic [SEQ_W-1:0]   next_q, next_d;
  logic [BYTE_W-1:0]  acked_q, acked_d;
  logic [BYTE_W-1:0]  sent_q, sent_d;
  logic [RING_AW-1:0] head_q, head_d;
  logic               timer_q, timer_d;

  // current event
  logic [1:0]        req_q;
  logic [SEQ_W-1:0]  ack_q, sseq_q;
  logic [LEN_W-1:0]  slen_q, slen_d;
  logic [1:0]        rtx_q, rtx_d;
  logic [RCNT_W-1:0] rcnt_q, rcnt_d;

  // send check
  logic              can_q;
  logic [BYTE_W:0]   wroom_q;
  logic [BYTE_W-1:0] troom_q;

  // ACK summation
  logic [SEQ_W-1:0] d_q, cnt_q;
  logic             rv_q;

  // divider
  logic [WIN_W:0]    rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DCNT_W-1:0] dcnt_q;

  // output word
  logic             oval_q;
  logic [OUT_W-1:0] odata_q;

  // ring
  logic               ram_we;
  logic [RING_AW-1:0] ram_waddr, ram_raddr;
  logic [LEN_W-1:0]   ram_rdata;

  logic [SEQ_W-1:0]  outs, d_now;
  logic [WIN_W-1:0]  swin;
  logic [BYTE_W:0]   limit;
  logic [LEN_W-1:0]  len_now;
  logic [WIN_W:0]    rem_sh, divisor;
  logic [2:0]        dup_n;

  assign outs  = next_q - base_q;
  assign swin  = (cwnd_q < wlim_q) ? cwnd_q : wlim_q;
  assign limit = {1'b0, acked_q} + {{(BYTE_W+1-WIN_W){1'b0}}, swin};
  assign d_now = ack_q + SEQ_W'(1) - base_q;

  // segment length: smallest of window room, MSS and transfer remainder
  always_comb begin
    logic [BYTE_W:0] m;
    m = wroom_q;
    if (m > (BYTE_W+1)'(MSS)) m = (BYTE_W+1)'(MSS);
    if (m > {1'b0, troom_q}) m = {1'b0, troom_q};
    len_now = m[LEN_W-1:0];
  end

  assign divisor = (cwnd_q == '0) ? (WIN_W+1)'(1) : {1'b0, cwnd_q};
  assign rem_sh  = {rem_q[WIN_W-1:0], quo_q[NUM_W-1]};
  assign dup_n   = (dup_q == DUP_MAX) ? DUP_MAX : dup_q + 3'd1;

  assign ram_we    = cmd_i.send_do && can_q;
  assign ram_waddr = head_q + outs[RING_AW-1:0];
  assign ram_raddr = head_q + cnt_q[RING_AW-1:0];

  rswe_ram #(
    .Width(LEN_W),
    .Depth(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(len_now),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // state update per command
  always_comb begin
    logic [BYTE_W:0] ss;
    cwnd_d  = cwnd_q;
    thr_d   = thr_q;
    phase_d = phase_q;
    dup_d   = dup_q;
    base_d  = base_q;
    next_d  = next_q;
    acked_d = acked_q;
    sent_d  = sent_q;
    head_d  = head_q;
    timer_d = timer_q;
    slen_d  = slen_q;
    rtx_d   = rtx_q;
    rcnt_d  = rcnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ss      = '0;

    if (cmd_i.capture) begin
      slen_d = '0;
      rtx_d  = RTX_NONE;
      rcnt_d = '0;
    end
    if (cmd_i.send_do && can_q) begin
      slen_d = len_now;
      if (base_q == next_q) timer_d = 1'b1;
      next_d = next_q + SEQ_W'(1);
      sent_d = sent_q + BYTE_W'(len_now);
    end
    if ((cmd_i.sum_step && rv_q) || cmd_i.sum_drain) begin
      acked_d = acked_q + BYTE_W'(ram_rdata);
    end
    if (cmd_i.ack_upd) begin
      head_d = head_q + d_q[RING_AW-1:0];
      dup_d  = '0;
      base_d = ack_q + SEQ_W'(1);
      unique case (phase_q)
        PH_SLOW: begin
          ss     = {9'd0, cwnd_q} + (BYTE_W+1)'(d_q) * (BYTE_W+1)'(MSS);
          cwnd_d = sat24(ss);
          if (sat24(ss) >= thr_q) phase_d = PH_AVOID;
        end
        PH_AVOID: begin
          rem_d = '0;
          quo_d = NUM_W'(d_q) * NUM_W'(MSS_SQ);
        end
        PH_RECOV: begin
          cwnd_d  = thr_q;
          phase_d = PH_AVOID;
        end
        default: ;
      endcase
    end
    // restoring divide, one quotient bit a cycle
    if (cmd_i.div_step) begin
      if (rem_sh >= divisor) begin
        rem_d = rem_sh - divisor;
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.div_fin) begin
      cwnd_d = sat24({9'd0, cwnd_q} + (BYTE_W+1)'(quo_q));
    end
    if (cmd_i.dup_upd) begin
      dup_d = dup_n;
      if ((phase_q == PH_SLOW || phase_q == PH_AVOID) && dup_n == DUP_TRG) begin
        thr_d   = cwnd_q >> 1;
        cwnd_d  = sat24({9'd0, cwnd_q >> 1} + {9'd0, MSS3_W24});
        phase_d = PH_RECOV;
        rtx_d   = RTX_FAST;
        rcnt_d  = outs[RCNT_W-1:0];
      end else if (phase_q == PH_RECOV) begin
        cwnd_d = sat24({9'd0, cwnd_q} + {9'd0, MSS_W24});
      end
    end
    if (cmd_i.tmo_upd && timer_q) begin
      rtx_d   = RTX_TMO;
      rcnt_d  = outs[RCNT_W-1:0];
      thr_d   = cwnd_q >> 1;
      cwnd_d  = MSS_W24;
      dup_d   = '0;
      phase_d = PH_SLOW;
    end
    if (cmd_i.timer_upd) begin
      timer_d = (base_q != next_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      wlim_q  <= INIT_WLIM;
      cwnd_q  <= MSS_W24;
      thr_q   <= INIT_THR;
      phase_q <= PH_SLOW;
      dup_q   <= '0;
      base_q  <= '0;
      next_q  <= '0;
      acked_q <= '0;
      sent_q  <= '0;
      head_q  <= '0;
      timer_q <= 1'b0;
      rv_q    <= 1'b0;
      cnt_q   <= '0;
      dcnt_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      cwnd_q  <= cwnd_d;
      phase_q <= phase_d;
      dup_q   <= dup_d;
      base_q  <= base_d;
      next_q  <= next_d;
      acked_q <= acked_d;
      sent_q  <= sent_d;
      head_q  <= head_d;
      timer_q <= timer_d;
      thr_q   <= thr_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOTAL: total_q <= cfg_data_i;
          CFG_WLIM:  wlim_q  <= cfg_data_i[WIN_W-1:0];
          CFG_ITHR:  thr_q   <= cfg_data_i[WIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.ack_chk) begin
        cnt_q <= '0;
        rv_q  <= 1'b0;
      end else if (cmd_i.sum_step) begin
        cnt_q <= cnt_q + SEQ_W'(1);
        rv_q  <= 1'b1;
      end else if (cmd_i.sum_drain) begin
        rv_q  <= 1'b0;
      end
      if (cmd_i.ack_upd) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      if (cmd_i.load_out) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    slen_q <= slen_d;
    rtx_q  <= rtx_d;
    rcnt_q <= rcnt_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    if (cmd_i.capture) begin
      req_q  <= in_req_i;
      ack_q  <= in_ack_i;
      sseq_q <= next_q;
    end
    if (cmd_i.send_chk) begin
      can_q   <= ({1'b0, sent_q} < limit) && (sent_q < total_q)
                 && ({1'b0, outs} < (SEQ_W+1)'(RING_CAP));
      wroom_q <= limit - {1'b0, sent_q};
      troom_q <= total_q - sent_q;
    end
    if (cmd_i.ack_chk) begin
      d_q <= d_now;
    end
    if (cmd_i.load_out) begin
      odata_q <= {(acked_q == total_q), timer_q, swin, phase_q, thr_q, cwnd_q,
                  rcnt_q, rtx_q, sseq_q, slen_q};
    end
  end

  assign sts_o.req      = cmd_i.capture ? in_req_i : req_q;
  assign sts_o.in_win   = (d_now != '0) && (d_now <= outs);
  assign sts_o.sum_last = (cnt_q + SEQ_W'(1)) == d_q;
  assign sts_o.div_last = dcnt_q == DCNT_W'(NUM_W - 1);
  assign sts_o.avoid    = (phase_q == PH_AVOID);
  assign sts_o.out_free = !oval_q || out_ready_i;

  assign out_valid_o = oval_q;
  assign out_data_o  = odata_q;

endmodule

[src/reno_sender_window_engine_top.sv]
// Reno sender window engine: a Go-back-N sender with Reno congestion control.
// One event goes in (send opportunity, ACK or timeout) and one result word comes
// out. Events are handled one at a time. A new ACK sums the lengths of the
// segments it acknowledges from the ring before it updates the window; in
// congestion avoidance a 29-step restoring divider computes the window growth.
// The result sits in an output register, so the next event is taken while the
// previous result still waits; that event then holds in its last cycle until
// the sink frees the register.
// No clearing pass after reset.
// Depends on rswe_pkg, rswe_ctrl, rswe_dp and rswe_ram.
module reno_sender_window_engine_top import rswe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // ack_num[7:0]
  input  logic [1:0]   s_axis_tuser,   // req_type[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // send_len[10:0], send_seq[18:11], retransmit[20:19], resend_count[27:21],
  // cong_window[51:28], slow_threshold[75:52], phase[77:76],
  // send_window[101:78], timer_running[102], all_acked[103]
  output logic [103:0] m_axis_tdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rswe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rswe_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (s_axis_tuser),
    .in_ack_i   (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

[src/rswe_checker.sv]
// Port-level checks on the window engine's result stream, bound to the top.
// Depends on rswe_pkg and reno_sender_window_engine_top.
module rswe_checker import rswe_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // no resend count without a resend order
  a_rcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[20:19] == RTX_NONE |-> m_axis_tdata[27:21] == '0)
    else $error("resend count without order");

  // send window never exceeds the congestion window
  a_swin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[101:78] <= m_axis_tdata[51:28])
    else $error("send window above cwnd");

  // a new segment is never sent together with a resend order and is at most MSS long
  a_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10:0] != '0 |->
      m_axis_tdata[20:19] == RTX_NONE && m_axis_tdata[10:0] <= LEN_W'(MSS))
    else $error("bad segment length or mixed order");

endmodule

bind reno_sender_window_engine_top rswe_checker u_rswe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
